>>> rtl/psq_pkg.sv
// Package for the pitch scale quantiser: scale tables, semitone table and log2 constant.
package psq_pkg;

    typedef logic [11:0] t_pc_mask;

    localparam int unsigned HZ_W      = 25;
    localparam int unsigned LOG_W     = 21;
    localparam int unsigned MANT_W    = 31;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned NUM_PC    = 12;
    localparam logic [3:0]  CHROMATIC = 4'd12;
    localparam logic [HZ_W-1:0] HZ_MAX = 25'h1FFFFFF;
    localparam logic [24:0] HZ_A4_Q10 = 25'd450560;

    // Scale masks, bit i set when interval i above the root is in the scale.
    localparam t_pc_mask SCALE_MASK [16] = '{
        12'hAB5, 12'h5AD, 12'h6AD, 12'h5AB, 12'hAD5, 12'h6B5, 12'h56B, 12'h9AD,
        12'hAAD, 12'h295, 12'h4A9, 12'h4E9, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF
    };

    // Frequency of each semitone above A, in Hz with 16 fraction bits.
    localparam logic [25:0] SEMI_HZ [12] = '{
        26'd28835840, 26'd30550508, 26'd32367136, 26'd34291786,
        26'd36330882, 26'd38491228, 26'd40780036, 26'd43204943,
        26'd45774043, 26'd48495909, 26'd51379626, 26'd54434817
    };

    // Bit-serial log2 with 16 fraction bits; only evaluated at elaboration.
    function automatic logic [LOG_W-1:0] log2_q16(input logic [24:0] x);
        longint unsigned m;
        int unsigned     e;
        logic [15:0]     frac;
        e    = 0;
        frac = '0;
        for (int i = 0; i < 25; i++) begin
            if (x[i]) begin
                e = i;
            end
        end
        m = longint'(x) << (30 - e);
        for (int i = 0; i < 16; i++) begin
            m    = (m * m) >> 30;
            frac = {frac[14:0], 1'b0};
            if (m >= (64'd2 << 30)) begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return {5'(e), frac};
    endfunction

    localparam logic [LOG_W-1:0] LOG2_440 = log2_q16(HZ_A4_Q10);

endpackage

>>> rtl/pitch_scale_quantizer_top.sv
// Pitch scale quantiser: snaps a detected frequency to the nearest note of a key and scale.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | input     | i_valid / o_ready     | i_detected_hz
//  out     | output    | o_valid / i_ready     | o_valid_res, o_target_note, o_target_hz,
//          |           |                       | o_cents_offset, o_pitch_class, o_octave,
//          |           |                       | o_name_valid
//  cfg     | input     | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// One item per cycle is accepted while o_ready is high; it passes through 26 register stages,
// from the input register to the output register.
// The depth is set mostly by the sixteen squaring stages of the log2 mantissa, one multiply each.
// Reset is synchronous and active low; it clears the stage valid bits and sets both
// configuration registers to chromatic. A stall holds each full stage whose successor cannot
// move, while empty stages keep filling, so an item is never lost or repeated.
module pitch_scale_quantizer_top #(
    parameter int SEARCH_SPAN = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [24:0]         i_detected_hz,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_valid_res,
    output logic signed [8:0]   o_target_note,
    output logic [24:0]         o_target_hz,
    output logic signed [14:0]  o_cents_offset,
    output logic [3:0]          o_pitch_class,
    output logic signed [5:0]   o_octave,
    output logic                o_name_valid,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [3:0]          i_cfg_data
);

    localparam int NSTG = 26;
    localparam int NSQ  = 16;
    localparam int NC   = 2 * SEARCH_SPAN + 1;
    localparam int KW   = $clog2(SEARCH_SPAN + 1) + 1;
    localparam int CIW  = $clog2(NC);
    localparam logic [0:0] CFG_KEY = 1'b0;

    // ---------------- configuration ----------------
    logic [3:0] r_key;
    logic [3:0] r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= psq_pkg::CHROMATIC;
            r_mode <= psq_pkg::CHROMATIC;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_KEY) begin
                r_key <= i_cfg_data;
            end else begin
                r_mode <= i_cfg_data;
            end
        end
    end

    // ---------------- flow control ----------------
    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   adv;

    always_comb begin
        adv[NSTG] = i_ready;
        for (int j = NSTG - 1; j >= 0; j--) begin
            adv[j] = !r_v[j] || adv[j+1];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int j = 0; j < NSTG; j++) begin
                if (adv[j]) begin
                    r_v[j] <= (j == 0) ? i_valid : r_v[(j == 0) ? 0 : j - 1];
                end
            end
        end
    end

    // ---------------- stage 0: input register ----------------
    logic [24:0] r_x;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_x <= i_detected_hz;
        end
    end

    // ---------------- stage 1: normalise mantissa ----------------
    logic [psq_pkg::MANT_W-1:0] r_m   [NSQ+1];
    logic [4:0]                 r_e   [NSQ+1];
    logic [15:0]                r_f   [NSQ+1];
    logic                       r_nz  [NSQ+1];
    logic [4:0]                 n_e;

    always_comb begin
        n_e = '0;
        for (int i = 0; i < 25; i++) begin
            if (r_x[i]) begin
                n_e = 5'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_m[0]  <= {6'b0, r_x} << (5'd30 - n_e);
            r_e[0]  <= n_e;
            r_f[0]  <= '0;
            r_nz[0] <= (r_x != '0);
        end
    end

    // ---------------- stages 2..17: one squaring per stage ----------------
    for (genvar k = 1; k <= NSQ; k++) begin : g_sq
        logic [2*psq_pkg::MANT_W-1:0] prod;
        logic [31:0]                  sq;
        assign prod = r_m[k-1] * r_m[k-1];
        assign sq   = prod[61:30];

        always_ff @(posedge i_clk) begin
            if (adv[k+1]) begin
                r_m[k]  <= sq[31] ? sq[31:1] : sq[30:0];
                r_f[k]  <= {r_f[k-1][14:0], sq[31]};
                r_e[k]  <= r_e[k-1];
                r_nz[k] <= r_nz[k-1];
            end
        end
    end

    // ---------------- stage 18: fractional note ----------------
    logic [psq_pkg::LOG_W-1:0] lg;
    logic signed [21:0]        dl;
    logic signed [25:0]        dlx;
    logic signed [25:0]        r_note;
    logic                      r_nz18;

    assign lg  = {r_e[NSQ], r_f[NSQ]};
    assign dl  = $signed({1'b0, lg}) - $signed({1'b0, psq_pkg::LOG2_440});
    assign dlx = 26'(dl);

    always_ff @(posedge i_clk) begin
        if (adv[18]) begin
            r_note <= (dlx <<< 3) + (dlx <<< 2) + 26'sd4521984;
            r_nz18 <= r_nz[NSQ];
        end
    end

    // ---------------- stage 19: round to centre note ----------------
    logic signed [25:0] pos_sum;
    logic signed [25:0] neg_sum;
    logic signed [8:0]  n_ctr;
    logic signed [8:0]  r_ctr19;
    logic signed [16:0] r_dlt19;
    logic               r_nz19;

    assign pos_sum = r_note + 26'sd32768;
    assign neg_sum = -r_note + 26'sd32768;
    assign n_ctr   = (r_note >= 0) ? $signed(pos_sum[24:16]) : -$signed(neg_sum[24:16]);

    always_ff @(posedge i_clk) begin
        if (adv[19]) begin
            r_ctr19 <= n_ctr;
            r_dlt19 <= 17'(r_note - (26'(n_ctr) <<< 16));
            r_nz19  <= r_nz18;
        end
    end

    // ---------------- stage 20: divide centre by twelve ----------------
    logic [8:0]         cv;
    logic [17:0]        cprod;
    logic [8:0]         r_cv20;
    logic [4:0]         r_q20;
    logic signed [8:0]  r_ctr20;
    logic signed [16:0] r_dlt20;
    logic               r_nz20;

    // The offset is a multiple of twelve that keeps every centre positive.
    assign cv    = 9'(r_ctr19) + 9'd168;
    assign cprod = 18'(cv) * 18'd683;

    always_ff @(posedge i_clk) begin
        if (adv[20]) begin
            r_cv20  <= cv;
            r_q20   <= cprod[17:13];
            r_ctr20 <= r_ctr19;
            r_dlt20 <= r_dlt19;
            r_nz20  <= r_nz19;
        end
    end

    // ---------------- stage 21: centre pitch class and octave ----------------
    logic [3:0]         r_pc21;
    logic signed [5:0]  r_qc21;
    logic signed [8:0]  r_ctr21;
    logic signed [16:0] r_dlt21;
    logic               r_nz21;

    always_ff @(posedge i_clk) begin
        if (adv[21]) begin
            r_pc21  <= 4'(r_cv20 - 9'(r_q20) * 9'd12);
            r_qc21  <= $signed(6'(r_q20) - 6'd14);
            r_ctr21 <= r_ctr20;
            r_dlt21 <= r_dlt20;
            r_nz21  <= r_nz20;
        end
    end

    // ---------------- stage 22: nearest allowed candidate ----------------
    psq_pkg::t_pc_mask pc_ok;
    logic [NC-1:0]     cand_ok;
    logic signed [KW-1:0] n_k;
    logic signed [KW-1:0] r_k22;
    logic [3:0]         r_pc22;
    logic signed [5:0]  r_qc22;
    logic signed [8:0]  r_ctr22;
    logic signed [16:0] r_dlt22;
    logic               r_nz22;

    always_comb begin
        logic [3:0] iv;
        pc_ok = '1;
        for (int p = 0; p < psq_pkg::NUM_PC; p++) begin
            iv = (4'(p) >= r_key) ? 4'(4'(p) - r_key) : 4'(4'(p) + 4'd12 - r_key);
            if (r_key < psq_pkg::CHROMATIC && r_mode < psq_pkg::CHROMATIC) begin
                pc_ok[p] = psq_pkg::SCALE_MASK[r_mode][iv];
            end
        end
    end

    always_comb begin
        logic signed [5:0] t6;
        logic [3:0]        pc;
        for (int i = 0; i < NC; i++) begin
            t6 = $signed({2'b0, r_pc21}) + 6'(i - SEARCH_SPAN);
            if (t6 < 0) begin
                pc = 4'(t6 + 6'sd12);
            end else if (t6 >= 6'sd12) begin
                pc = 4'(t6 - 6'sd12);
            end else begin
                pc = 4'(t6);
            end
            cand_ok[i] = pc_ok[pc];
        end
    end

    // Candidates are tried in order of distance, the lower note first on equal distance.
    // A note exactly half a step below the centre puts the next lower note ahead.
    always_comb begin
        int   koff;
        logic found;
        logic half_low;
        logic above;
        found    = 1'b0;
        half_low = (r_dlt21 == -17'sd32768);
        above    = (r_dlt21 > 0);
        n_k      = '0;
        for (int i = 0; i < NC; i++) begin
            if (half_low) begin
                koff = (i == 2 * SEARCH_SPAN) ? SEARCH_SPAN :
                       ((i % 2) == 1) ? (i / 2) : -((i / 2) + 1);
            end else if (above) begin
                koff = (i == 0) ? 0 : ((i % 2) == 1) ? ((i + 1) / 2) : -(i / 2);
            end else begin
                koff = (i == 0) ? 0 : ((i % 2) == 1) ? -((i + 1) / 2) : (i / 2);
            end
            if (!found && cand_ok[CIW'(koff + SEARCH_SPAN)]) begin
                found = 1'b1;
                n_k   = KW'(koff);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[22]) begin
            r_k22   <= n_k;
            r_pc22  <= r_pc21;
            r_qc22  <= r_qc21;
            r_ctr22 <= r_ctr21;
            r_dlt22 <= r_dlt21;
            r_nz22  <= r_nz21;
        end
    end

    // ---------------- stage 23: target note ----------------
    logic signed [5:0]  tt;
    logic [3:0]         n_pcb;
    logic signed [5:0]  n_qb;
    logic signed [9:0]  r_b23;
    logic [3:0]         r_pcb23;
    logic signed [5:0]  r_qb23;
    logic signed [20:0] r_dk23;
    logic               r_nz23;

    assign tt = $signed({2'b0, r_pc22}) + 6'(r_k22);

    always_comb begin
        if (tt < 0) begin
            n_pcb = 4'(tt + 6'sd12);
            n_qb  = r_qc22 - 6'sd1;
        end else if (tt >= 6'sd12) begin
            n_pcb = 4'(tt - 6'sd12);
            n_qb  = r_qc22 + 6'sd1;
        end else begin
            n_pcb = 4'(tt);
            n_qb  = r_qc22;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[23]) begin
            r_b23   <= 10'(r_ctr22) + 10'(r_k22);
            r_pcb23 <= n_pcb;
            r_qb23  <= n_qb;
            r_dk23  <= (21'(r_k22) <<< 16) - 21'(r_dlt22);
            r_nz23  <= r_nz22;
        end
    end

    // ---------------- stage 24: cents product, frequency table ----------------
    logic [4:0]         rr;
    logic [3:0]         n_r;
    logic               qa;
    logic signed [27:0] r_d100;
    logic [25:0]        r_t24;
    logic signed [6:0]  r_s24;
    logic signed [9:0]  r_b24;
    logic [3:0]         r_pcb24;
    logic signed [5:0]  r_qb24;
    logic               r_nz24;

    // C is three semitones above A, so the table index is the pitch class plus three.
    assign rr  = 5'(r_pcb23) + 5'd3;
    assign qa  = (rr >= 5'd12);
    assign n_r = qa ? 4'(rr - 5'd12) : 4'(rr);

    always_ff @(posedge i_clk) begin
        if (adv[24]) begin
            r_d100  <= 28'(r_dk23) * 28'sd100;
            r_t24   <= psq_pkg::SEMI_HZ[n_r];
            r_s24   <= 7'(r_qb23) - 7'sd12 + $signed({6'b0, qa});
            r_b24   <= r_b23;
            r_pcb24 <= r_pcb23;
            r_qb24  <= r_qb23;
            r_nz24  <= r_nz23;
        end
    end

    // ---------------- stage 25: output register ----------------
    logic [27:0]        mag;
    logic [27:0]        csum;
    logic [15:0]        cmag;
    logic signed [14:0] n_cents;
    logic [6:0]         shn;
    logic [4:0]         sh;
    logic [26:0]        hsum;
    logic [24:0]        n_hz;
    logic signed [8:0]  n_note;

    assign mag  = (r_d100 < 0) ? 28'(-r_d100) : 28'(r_d100);
    assign csum = mag + 28'd2048;

    always_comb begin
        cmag = (csum[27:12] > 16'd9600) ? 16'd9600 : csum[27:12];
        n_cents = (r_d100 < 0) ? -$signed(15'(cmag)) : $signed(15'(cmag));
    end

    assign shn  = 7'(-r_s24);
    assign sh   = (shn >= 7'd27) ? 5'd27 : 5'(shn);
    assign hsum = {1'b0, r_t24} + (27'd1 << (sh - 5'd1));

    always_comb begin
        if (r_s24 > 0) begin
            n_hz = psq_pkg::HZ_MAX;
        end else if (r_s24 == 0) begin
            n_hz = (r_t24 > 26'(psq_pkg::HZ_MAX)) ? psq_pkg::HZ_MAX : 25'(r_t24);
        end else if (sh == 5'd27) begin
            n_hz = '0;
        end else begin
            n_hz = 25'(hsum >> sh);
        end
    end

    always_comb begin
        if (r_b24 > 10'sd255) begin
            n_note = 9'sd255;
        end else if (r_b24 < -10'sd256) begin
            n_note = -9'sd256;
        end else begin
            n_note = 9'(r_b24);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[25]) begin
            o_valid_res    <= r_nz24;
            o_target_note  <= r_nz24 ? n_note : '0;
            o_target_hz    <= r_nz24 ? n_hz : '0;
            o_cents_offset <= r_nz24 ? n_cents : '0;
            o_pitch_class  <= r_nz24 ? r_pcb24 : '0;
            o_octave       <= (r_nz24 && r_b24 >= 0) ? r_qb24 - 6'sd1 : '0;
            o_name_valid   <= r_nz24 && (r_b24 >= 0);
        end
    end

endmodule
